### hw/rtl/ucer_pkg.sv
// types, codes and table lengths shared by the endpoint zero responder
`timescale 1ns / 1ps

package ucer_pkg;

	localparam int unsigned MAX_PACKET = 64;

	localparam logic [1:0] OP_SETUP    = 2'd0;
	localparam logic [1:0] OP_IN_DONE  = 2'd1;
	localparam logic [1:0] OP_OUT_DONE = 2'd2;
	localparam logic [1:0] OP_BUS_RST  = 2'd3;

	localparam logic [2:0] ACT_IN_DATA    = 3'd0;
	localparam logic [2:0] ACT_IN_STATUS  = 3'd1;
	localparam logic [2:0] ACT_ARM_OUT    = 3'd2;
	localparam logic [2:0] ACT_OUT_STATUS = 3'd3;
	localparam logic [2:0] ACT_SET_ADDR   = 3'd4;
	localparam logic [2:0] ACT_REBOOT     = 3'd5;

	localparam logic [2:0] TAB_DEVICE   = 3'd0;
	localparam logic [2:0] TAB_CONFIG   = 3'd1;
	localparam logic [2:0] TAB_LANGUAGE = 3'd2;
	localparam logic [2:0] TAB_MAKER    = 3'd3;
	localparam logic [2:0] TAB_PRODUCT  = 3'd4;
	localparam logic [2:0] TAB_SERIAL   = 3'd5;
	localparam logic [2:0] TAB_LINE     = 3'd6;

	localparam logic [7:0] RT_DIR_IN     = 8'h80;
	localparam logic [7:0] RT_STD_OUT    = 8'h00;
	localparam logic [7:0] RT_STD_IN     = 8'h80;
	localparam logic [7:0] RT_TYPE_MASK  = 8'h60;
	localparam logic [7:0] RT_TYPE_CLASS = 8'h20;
	localparam logic [7:0] RT_VENDOR_IF  = 8'h41;

	localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
	localparam logic [7:0] REQ_GET_DESC    = 8'd6;
	localparam logic [7:0] REQ_RESET       = 8'h01;

	localparam logic [7:0] DT_DEVICE = 8'd1;
	localparam logic [7:0] DT_CONFIG = 8'd2;
	localparam logic [7:0] DT_STRING = 8'd3;

	localparam logic [6:0] MAX_PKT_LEN = 7'(MAX_PACKET);

	typedef struct packed {
		logic [2:0] action;
		logic       data_pid;
		logic [6:0] packet_length;
		logic [2:0] source_table;
		logic [6:0] source_offset;
		logic [6:0] device_address;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  request_type;
		logic [7:0]  request;
		logic [15:0] value;
		logic [15:0] length;
	} event_t;

	function automatic logic [6:0] table_len(input logic [2:0] tab);
		logic [6:0] len;
		case (tab)
			TAB_DEVICE:   len = 7'd18;
			TAB_CONFIG:   len = 7'd84;
			TAB_LANGUAGE: len = 7'd4;
			TAB_MAKER:    len = 7'd20;
			TAB_PRODUCT:  len = 7'd30;
			TAB_SERIAL:   len = 7'd10;
			TAB_LINE:     len = 7'd7;
			default:      len = 7'd0;
		endcase
		return len;
	endfunction

endpackage

### hw/rtl/usb_control_endpoint_responder.sv
// top level of the endpoint zero control responder
`timescale 1ns / 1ps

// Takes one endpoint zero event per request (setup, in done, out done, bus
// reset) into an input register and decides its zero, one or two results
// from that register, updating the control transfer state once they go into
// the queue. Results leave through a two-entry queue, so a new event is taken
// every cycle while the queue has room; an event waits in the input register
// only until the queue has room for all its results. A reset request gives
// two results. Results pass through the input register, then the queue.

module usb_control_endpoint_responder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        evt_valid,
	output logic        evt_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  request_type,
	input  logic [7:0]  request,
	input  logic [15:0] value,
	input  logic [15:0] length,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  action,
	output logic        data_pid,
	output logic [6:0]  packet_length,
	output logic [2:0]  source_table,
	output logic [6:0]  source_offset,
	output logic [6:0]  device_address,
	output logic        last
);
	import ucer_pkg::*;

	event_t     evt_s1;
	logic       valid_s1;
	logic       fire;
	logic       pop;
	logic [1:0] res_count;
	logic [1:0] q_count;
	logic [1:0] free_slots;
	logic [1:0] push_count;
	result_t    res0;
	result_t    res1;
	result_t    head;

	assign pop = res_valid & ~res_stall;
	assign free_slots = 2'd2 - q_count + {1'b0, pop};
	assign fire = valid_s1 & (res_count <= free_slots);
	assign evt_stall = valid_s1 & ~fire;
	assign push_count = fire ? res_count : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_valid && !evt_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && !evt_stall) begin
			evt_s1.opcode <= opcode;
			evt_s1.request_type <= request_type;
			evt_s1.request <= request;
			evt_s1.value <= value;
			evt_s1.length <= length;
		end
	end

	ucer_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.evt       (evt_s1),
		.res0      (res0),
		.res1      (res1),
		.res_count (res_count)
	);

	ucer_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (push_count),
		.push0      (res0),
		.push1      (res1),
		.pop        (pop),
		.head       (head),
		.count      (q_count)
	);

	assign res_valid = (q_count != 2'd0);
	assign action = head.action;
	assign data_pid = head.data_pid;
	assign packet_length = head.packet_length;
	assign source_table = head.source_table;
	assign source_offset = head.source_offset;
	assign device_address = head.device_address;
	assign last = head.last;

endmodule

### hw/rtl/ucer_core.sv
// control transfer state and per-event decision logic
`timescale 1ns / 1ps

module ucer_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  ucer_pkg::event_t evt,
	output ucer_pkg::result_t res0,
	output ucer_pkg::result_t res1,
	output logic [1:0]       res_count
);
	import ucer_pkg::*;

	typedef struct packed {
		logic       next_pid;
		logic [6:0] bytes_left;
		logic [2:0] current_table;
		logic [6:0] current_offset;
		logic       in_data_stage;
		logic       out_data_stage;
		logic [6:0] address_waiting;
	} ep_state_t;

	ep_state_t st_q;
	ep_state_t st_nxt;

	always_comb begin
		logic       do_table;
		logic       do_status;
		logic       do_reboot;
		logic       do_chunk;
		logic [2:0] tab;
		logic [6:0] tl;
		logic [6:0] bl_src;
		logic [6:0] off_src;
		logic [2:0] tab_src;
		logic       pid_src;
		logic [6:0] chunk;

		st_nxt = st_q;
		res0 = '0;
		res1 = '0;
		res_count = 2'd0;
		do_table = 1'b0;
		do_status = 1'b0;
		do_reboot = 1'b0;
		do_chunk = 1'b0;
		tab = TAB_DEVICE;
		bl_src = st_q.bytes_left;
		off_src = st_q.current_offset;
		tab_src = st_q.current_table;
		pid_src = st_q.next_pid;

		unique case (evt.opcode)
			OP_SETUP: begin
				st_nxt.next_pid = 1'b1;
				if (!evt.request_type[7] && evt.length != 16'd0) begin
					st_nxt.next_pid = 1'b0;
					st_nxt.bytes_left = '0;
					st_nxt.in_data_stage = 1'b0;
					st_nxt.out_data_stage = 1'b1;
					res0.action = ACT_ARM_OUT;
					res0.data_pid = 1'b1;
					res0.packet_length = MAX_PKT_LEN;
					res_count = 2'd1;
				end else if (evt.request_type == RT_STD_OUT) begin
					if (evt.request == REQ_SET_ADDRESS)
						st_nxt.address_waiting = evt.value[6:0];
					do_status = 1'b1;
				end else if (evt.request_type == RT_STD_IN &&
						evt.request == REQ_GET_DESC) begin
					do_table = 1'b1;
					if (evt.value[15:8] == DT_DEVICE) begin
						tab = TAB_DEVICE;
					end else if (evt.value[15:8] == DT_CONFIG) begin
						tab = TAB_CONFIG;
					end else if (evt.value[15:8] == DT_STRING) begin
						if (evt.value[7:0] == 8'd0)
							tab = TAB_LANGUAGE;
						else if (evt.value[7:0] == 8'd1)
							tab = TAB_MAKER;
						else if (evt.value[7:0] == 8'd2)
							tab = TAB_PRODUCT;
						else
							tab = TAB_SERIAL;
					end else begin
						do_table = 1'b0;
						do_status = 1'b1;
					end
				end else if ((evt.request_type & RT_TYPE_MASK) == RT_TYPE_CLASS) begin
					if ((evt.request_type & RT_DIR_IN) != 8'd0) begin
						do_table = 1'b1;
						tab = TAB_LINE;
					end else begin
						do_status = 1'b1;
					end
				end else if (evt.request_type == RT_VENDOR_IF && evt.request == REQ_RESET) begin
					do_status = 1'b1;
					do_reboot = 1'b1;
				end else begin
					do_status = 1'b1;
				end
			end
			OP_IN_DONE: begin
				if (st_q.bytes_left != 7'd0) begin
					do_chunk = 1'b1;
				end else if (st_q.in_data_stage) begin
					st_nxt.in_data_stage = 1'b0;
					st_nxt.next_pid = 1'b1;
					res0.action = ACT_OUT_STATUS;
					res0.data_pid = 1'b1;
					res_count = 2'd1;
				end else if (st_q.address_waiting != 7'd0) begin
					st_nxt.address_waiting = '0;
					res0.action = ACT_SET_ADDR;
					res0.device_address = st_q.address_waiting;
					res_count = 2'd1;
				end
			end
			OP_OUT_DONE: begin
				if (st_q.out_data_stage) begin
					st_nxt.out_data_stage = 1'b0;
					do_status = 1'b1;
				end
			end
			OP_BUS_RST: begin
				res0.action = ACT_SET_ADDR;
				res_count = 2'd1;
			end
			default: begin
			end
		endcase

		// descriptor or line coding read starts with offset zero
		tl = table_len(tab);
		if (do_table) begin
			bl_src = (evt.length < {9'd0, tl}) ? evt.length[6:0] : tl;
			off_src = '0;
			tab_src = tab;
			pid_src = 1'b1;
			st_nxt.current_table = tab;
			st_nxt.in_data_stage = 1'b1;
			do_chunk = 1'b1;
		end

		chunk = (bl_src > MAX_PKT_LEN) ? MAX_PKT_LEN : bl_src;
		if (do_chunk) begin
			st_nxt.next_pid = ~pid_src;
			st_nxt.current_offset = off_src + chunk;
			st_nxt.bytes_left = bl_src - chunk;
			res0.action = ACT_IN_DATA;
			res0.data_pid = pid_src;
			res0.packet_length = chunk;
			res0.source_table = tab_src;
			res0.source_offset = off_src;
			res_count = 2'd1;
		end

		if (do_status) begin
			st_nxt.next_pid = 1'b1;
			st_nxt.bytes_left = '0;
			st_nxt.in_data_stage = 1'b0;
			res0.action = ACT_IN_STATUS;
			res0.data_pid = 1'b1;
			res_count = 2'd1;
		end

		if (do_reboot) begin
			res1.action = ACT_REBOOT;
			res1.last = 1'b1;
			res_count = 2'd2;
		end else begin
			res0.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.next_pid <= 1'b1;
			st_q.bytes_left <= '0;
			st_q.current_table <= '0;
			st_q.current_offset <= '0;
			st_q.in_data_stage <= 1'b0;
			st_q.out_data_stage <= 1'b0;
			st_q.address_waiting <= '0;
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

endmodule

### hw/rtl/ucer_out_queue.sv
// two-entry result queue that takes up to two results in one cycle
`timescale 1ns / 1ps

module ucer_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_count,
	input  ucer_pkg::result_t push0,
	input  ucer_pkg::result_t push1,
	input  logic              pop,
	output ucer_pkg::result_t head,
	output logic [1:0]        count
);
	import ucer_pkg::*;

	result_t    slot0_q;
	result_t    slot1_q;
	logic [1:0] count_q;
	logic [1:0] kept;
	result_t    shifted;

	assign head = slot0_q;
	assign count = count_q;
	assign kept = count_q - {1'b0, pop};
	assign shifted = pop ? slot1_q : slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= kept + push_count;
		end
	end

	always_ff @(posedge clk) begin
		if (kept == 2'd0) begin
			slot0_q <= push0;
			slot1_q <= push1;
		end else if (kept == 2'd1) begin
			slot0_q <= shifted;
			slot1_q <= push0;
		end
	end

endmodule

### dv/usb_control_endpoint_responder_tb.sv
// self-checking testbench for the endpoint zero control responder with random events and stalls
`timescale 1ns / 1ps

module usb_control_endpoint_responder_tb;
	import ucer_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 7;
	localparam int ITEMS = 1350;
	localparam int LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_HOLD = 300;
	localparam int SHOWN = 10;

	localparam logic [7:0] RT_RECIP_IF = 8'h01;
	localparam logic [7:0] REQ_SET_LINE = 8'h20;
	localparam logic [7:0] REQ_GET_LINE = 8'h21;
	localparam logic [7:0] STR_LANGUAGE = 8'd0;
	localparam logic [7:0] STR_MAKER = 8'd1;
	localparam logic [7:0] STR_PRODUCT = 8'd2;

	class ep0_scoreboard;
		bit next_pid;
		bit in_stage;
		bit out_stage;
		logic [6:0] bytes_left;
		logic [6:0] cur_offset;
		logic [6:0] addr_waiting;
		logic [6:0] addr_now;
		logic [2:0] cur_table;
		result_t expected[$];
		int errors;

		function new();
			next_pid = 1'b1;
			in_stage = 1'b0;
			out_stage = 1'b0;
			bytes_left = '0;
			cur_offset = '0;
			addr_waiting = '0;
			addr_now = '0;
			cur_table = TAB_DEVICE;
			errors = 0;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function bit reading();
			return bytes_left != 0 || in_stage;
		endfunction

		function logic [6:0] desc_bytes(logic [2:0] tab);
			case (tab)
				TAB_DEVICE:   return 7'd18;
				TAB_CONFIG:   return 7'd84;
				TAB_LANGUAGE: return 7'd4;
				TAB_MAKER:    return 7'd20;
				TAB_PRODUCT:  return 7'd30;
				TAB_SERIAL:   return 7'd10;
				default:      return 7'd7;
			endcase
		endfunction

		function void emit(logic [2:0] act, bit pid, logic [6:0] len, logic [2:0] tab,
				logic [6:0] off, logic [6:0] addr);
			result_t r;
			r.action = act;
			r.data_pid = pid;
			r.packet_length = len;
			r.source_table = tab;
			r.source_offset = off;
			r.device_address = addr;
			r.last = 1'b0;
			expected.push_back(r);
		endfunction

		function void send_chunk();
			logic [6:0] n;
			n = (bytes_left > MAX_PKT_LEN) ? MAX_PKT_LEN : bytes_left;
			emit(ACT_IN_DATA, next_pid, n, cur_table, cur_offset, '0);
			next_pid = !next_pid;
			cur_offset = cur_offset + n;
			bytes_left = bytes_left - n;
		endfunction

		function void open_read(logic [2:0] tab, logic [15:0] wl);
			logic [6:0] tl;
			tl = desc_bytes(tab);
			cur_table = tab;
			cur_offset = '0;
			bytes_left = (wl < {9'd0, tl}) ? wl[6:0] : tl;
			in_stage = 1'b1;
			send_chunk();
		endfunction

		function void in_status();
			next_pid = 1'b1;
			bytes_left = '0;
			in_stage = 1'b0;
			emit(ACT_IN_STATUS, 1'b1, '0, '0, '0, '0);
		endfunction

		function void decode_setup(event_t ev);
			logic [7:0] rt;
			logic [7:0] rq;
			rt = ev.request_type;
			rq = ev.request;
			next_pid = 1'b1;
			if ((rt & RT_DIR_IN) == 0 && ev.length != 0) begin
				next_pid = 1'b0;
				bytes_left = '0;
				in_stage = 1'b0;
				out_stage = 1'b1;
				emit(ACT_ARM_OUT, 1'b1, MAX_PKT_LEN, '0, '0, '0);
			end else if (rt == RT_STD_OUT) begin
				if (rq == REQ_SET_ADDRESS)
					addr_waiting = ev.value[6:0];
				in_status();
			end else if (rt == RT_STD_IN && rq == REQ_GET_DESC) begin
				case (ev.value[15:8])
					DT_DEVICE: open_read(TAB_DEVICE, ev.length);
					DT_CONFIG: open_read(TAB_CONFIG, ev.length);
					DT_STRING: begin
						case (ev.value[7:0])
							STR_LANGUAGE: open_read(TAB_LANGUAGE, ev.length);
							STR_MAKER:    open_read(TAB_MAKER, ev.length);
							STR_PRODUCT:  open_read(TAB_PRODUCT, ev.length);
							default:      open_read(TAB_SERIAL, ev.length);
						endcase
					end
					default: in_status();
				endcase
			end else if ((rt & RT_TYPE_MASK) == RT_TYPE_CLASS) begin
				if ((rt & RT_DIR_IN) != 0)
					open_read(TAB_LINE, ev.length);
				else
					in_status();
			end else if (rt == RT_VENDOR_IF && rq == REQ_RESET) begin
				in_status();
				emit(ACT_REBOOT, 1'b0, '0, '0, '0, '0);
			end else begin
				in_status();
			end
		endfunction

		// returns how many results the event causes
		function int note_event(event_t ev);
			int start_n;
			start_n = expected.size();
			case (ev.opcode)
				OP_SETUP: decode_setup(ev);
				OP_IN_DONE: begin
					if (bytes_left != 0) begin
						send_chunk();
					end else if (in_stage) begin
						in_stage = 1'b0;
						next_pid = 1'b1;
						emit(ACT_OUT_STATUS, 1'b1, '0, '0, '0, '0);
					end else if (addr_waiting != 0) begin
						addr_now = addr_waiting;
						addr_waiting = '0;
						emit(ACT_SET_ADDR, 1'b0, '0, '0, '0, addr_now);
					end
				end
				OP_OUT_DONE: begin
					if (out_stage) begin
						out_stage = 1'b0;
						in_status();
					end
				end
				default: begin
					addr_now = '0;
					emit(ACT_SET_ADDR, 1'b0, '0, '0, '0, '0);
				end
			endcase
			if (expected.size() > start_n)
				expected[expected.size() - 1].last = 1'b1;
			return expected.size() - start_n;
		endfunction

		function void report(string what, result_t exp_r, result_t got);
			errors++;
			if (errors <= SHOWN) begin
				$display("mismatch %0d (%s): exp act=%0d pid=%0d len=%0d tab=%0d off=%0d",
					errors, what, exp_r.action, exp_r.data_pid, exp_r.packet_length,
					exp_r.source_table, exp_r.source_offset);
				$display("  exp addr=%0d last=%0d, got act=%0d pid=%0d len=%0d tab=%0d",
					exp_r.device_address, exp_r.last, got.action, got.data_pid,
					got.packet_length, got.source_table);
				$display("  got off=%0d addr=%0d last=%0d",
					got.source_offset, got.device_address, got.last);
			end
		endfunction

		function void check_result(result_t got);
			result_t exp_r;
			if (expected.size() == 0) begin
				report("unexpected result", '0, got);
			end else begin
				exp_r = expected.pop_front();
				if (got.action !== exp_r.action || got.data_pid !== exp_r.data_pid ||
						got.packet_length !== exp_r.packet_length ||
						got.source_table !== exp_r.source_table ||
						got.source_offset !== exp_r.source_offset ||
						got.device_address !== exp_r.device_address ||
						got.last !== exp_r.last)
					report("wrong field", exp_r, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        evt_valid;
	logic        evt_stall;
	logic [1:0]  opcode;
	logic [7:0]  request_type;
	logic [7:0]  request;
	logic [15:0] value;
	logic [15:0] length;
	logic        res_valid;
	logic        res_stall;
	logic [2:0]  action;
	logic        data_pid;
	logic [6:0]  packet_length;
	logic [2:0]  source_table;
	logic [6:0]  source_offset;
	logic [6:0]  device_address;
	logic        last;

	ep0_scoreboard sb;
	int fed;
	int cycles;
	bit hold_req;
	bit calm_tx;
	bit calm_rx;

	usb_control_endpoint_responder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.evt_valid      (evt_valid),
		.evt_stall      (evt_stall),
		.opcode         (opcode),
		.request_type   (request_type),
		.request        (request),
		.value          (value),
		.length         (length),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.action         (action),
		.data_pid       (data_pid),
		.packet_length  (packet_length),
		.source_table   (source_table),
		.source_offset  (source_offset),
		.device_address (device_address),
		.last           (last)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles == LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int idle_draw(bit calm);
		if (calm)
			return 0;
		return $urandom_range(0, 7);
	endfunction

	function automatic event_t make_setup(logic [7:0] rt, logic [7:0] rq, logic [15:0] val,
			logic [15:0] wl);
		event_t ev;
		ev.opcode = OP_SETUP;
		ev.request_type = rt;
		ev.request = rq;
		ev.value = val;
		ev.length = wl;
		return ev;
	endfunction

	// non-setup events carry random junk in the setup fields
	function automatic event_t bus_event(logic [1:0] op);
		event_t ev;
		ev.opcode = op;
		ev.request_type = 8'($urandom);
		ev.request = 8'($urandom);
		ev.value = 16'($urandom);
		ev.length = 16'($urandom);
		return ev;
	endfunction

	function automatic logic [15:0] draw_len();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(1, 130));
		endcase
	endfunction

	// entered and left at a falling edge; valid stays high into a back-to-back request
	task automatic push_event(input event_t ev);
		int gap;
		gap = idle_draw(calm_tx);
		if ($urandom_range(0, 31) == 0)
			calm_tx = !calm_tx;
		if (gap > 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		evt_valid <= 1'b1;
		opcode <= ev.opcode;
		request_type <= ev.request_type;
		request <= ev.request;
		value <= ev.value;
		length <= ev.length;
		do @(posedge clk); while (evt_stall);
		void'(sb.note_event(ev));
		fed++;
		@(negedge clk);
	endtask

	task automatic drain_wait();
		evt_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	task automatic finish_read();
		while (sb.reading() && $urandom_range(0, 19) != 0)
			push_event(bus_event(OP_IN_DONE));
	endtask

	task automatic random_transfer();
		int kind;
		logic [15:0] wl;
		logic [7:0] dtype;
		logic [7:0] idx;
		logic [7:0] rt;
		event_t ev;
		kind = $urandom_range(0, 19);
		wl = draw_len();
		if (kind < 6) begin
			case ($urandom_range(0, 3))
				0: dtype = DT_DEVICE;
				1: dtype = DT_CONFIG;
				2: dtype = DT_STRING;
				default: dtype = 8'($urandom);
			endcase
			idx = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
			push_event(make_setup(RT_STD_IN, REQ_GET_DESC, {dtype, idx}, wl));
			finish_read();
		end else if (kind < 8) begin
			push_event(make_setup(RT_DIR_IN | RT_TYPE_CLASS | RT_RECIP_IF, REQ_GET_LINE,
				16'($urandom), wl));
			finish_read();
		end else if (kind < 10) begin
			push_event(make_setup(RT_STD_OUT, REQ_SET_ADDRESS, 16'($urandom), '0));
			push_event(bus_event(OP_IN_DONE));
		end else if (kind < 13) begin
			rt = ($urandom_range(0, 1) != 0) ? (RT_TYPE_CLASS | RT_RECIP_IF) :
				(8'($urandom) & ~RT_DIR_IN);
			if (wl == 0)
				wl = 16'd1;
			push_event(make_setup(rt, REQ_SET_LINE, 16'($urandom), wl));
			if ($urandom_range(0, 7) != 0)
				push_event(bus_event(OP_OUT_DONE));
		end else if (kind < 14) begin
			push_event(make_setup(RT_VENDOR_IF, REQ_RESET, 16'($urandom), '0));
		end else if (kind < 15) begin
			push_event(bus_event(OP_BUS_RST));
		end else if (kind < 17) begin
			push_event(make_setup(8'($urandom), 8'($urandom), 16'($urandom), '0));
		end else begin
			ev = bus_event(2'($urandom));
			push_event(ev);
		end
	endtask

	initial begin : result_sink
		result_t got;
		int hold;
		int stall_left;
		hold = 0;
		stall_left = 0;
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				got = {action, data_pid, packet_length, source_table, source_offset,
					device_address, last};
				sb.check_result(got);
				stall_left = idle_draw(calm_rx);
				if ($urandom_range(0, 31) == 0)
					calm_rx = !calm_rx;
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold = LONG_HOLD;
			end
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				res_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		bit held;
		bit paused;
		arst_n = 1'b0;
		evt_valid = 1'b0;
		opcode = OP_SETUP;
		request_type = '0;
		request = '0;
		value = '0;
		length = '0;
		fed = 0;
		cycles = 0;
		hold_req = 1'b0;
		calm_tx = 1'b0;
		calm_rx = 1'b0;
		held = 1'b0;
		paused = 1'b0;
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// device descriptor, then its status
		push_event(make_setup(RT_STD_IN, REQ_GET_DESC, {DT_DEVICE, 8'd0}, 16'd64));
		push_event(bus_event(OP_IN_DONE));
		// config descriptor split over two packets
		push_event(make_setup(RT_STD_IN, REQ_GET_DESC, {DT_CONFIG, 8'd0}, 16'hFFFF));
		push_event(bus_event(OP_IN_DONE));
		push_event(bus_event(OP_IN_DONE));
		// zero-length read
		push_event(make_setup(RT_STD_IN, REQ_GET_DESC, {DT_STRING, STR_LANGUAGE}, 16'd0));
		push_event(bus_event(OP_IN_DONE));
		// string index above two falls back to serial
		push_event(make_setup(RT_STD_IN, REQ_GET_DESC, {DT_STRING, 8'hFF}, 16'd2));
		push_event(bus_event(OP_IN_DONE));
		// unknown descriptor type
		push_event(make_setup(RT_STD_IN, REQ_GET_DESC, 16'hFFFF, 16'd18));
		// address applied after status
		push_event(make_setup(RT_STD_OUT, REQ_SET_ADDRESS, 16'hFFFF, 16'd0));
		push_event(bus_event(OP_IN_DONE));
		// idle in and out done
		push_event(bus_event(OP_IN_DONE));
		push_event(bus_event(OP_OUT_DONE));
		// class out with data, then status
		push_event(make_setup(RT_TYPE_CLASS | RT_RECIP_IF, REQ_SET_LINE, 16'd0, 16'd7));
		push_event(bus_event(OP_OUT_DONE));
		// line coding read clamped to its size
		push_event(make_setup(RT_DIR_IN | RT_TYPE_CLASS | RT_RECIP_IF, REQ_GET_LINE, 16'd0,
			16'hFFFF));
		push_event(bus_event(OP_IN_DONE));
		push_event(make_setup(RT_VENDOR_IF, REQ_RESET, 16'd0, 16'd0));
		push_event(bus_event(OP_BUS_RST));
		push_event(make_setup(8'hFF, 8'hFF, 16'd0, 16'd0));
		// stale out stage survives a read
		push_event(make_setup(RT_TYPE_CLASS | RT_RECIP_IF, REQ_SET_LINE, 16'd0, 16'd5));
		push_event(make_setup(RT_STD_IN, REQ_GET_DESC, {DT_DEVICE, 8'd0}, 16'd8));
		push_event(bus_event(OP_OUT_DONE));
		drain_wait();

		fed = 0;
		while (fed < ITEMS) begin
			if (!held && fed >= ITEMS / 3) begin
				held = 1'b1;
				hold_req = 1'b1;
			end
			if (!paused && fed >= 2 * ITEMS / 3) begin
				paused = 1'b1;
				drain_wait();
			end
			random_transfer();
		end
		drain_wait();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
